>>> design/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants of the grid block count and clearance block:
// field widths, item kinds, status codes, register indexes and the structs
// passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int DEF_GRID_SIDE           = 64;
    localparam int DEF_COUNT_BITS          = 8;
    localparam int DEF_MAX_CLEARANCE_BOUND = 15;

    localparam int KIND_W     = 3;
    localparam int COORD_W    = 6;
    localparam int SUM_W      = COORD_W + 1;
    localparam int MAP_W      = 7;
    localparam int CLR_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [MAP_W-1:0] RST_MAP_WIDTH  = MAP_W'(64);
    localparam logic [MAP_W-1:0] RST_MAP_HEIGHT = MAP_W'(64);
    localparam logic [CLR_W-1:0] RST_CLR_LIMIT  = CLR_W'(15);

    typedef enum logic [KIND_W-1:0] {
        KIND_BLOCK          = 3'd0,
        KIND_UNBLOCK        = 3'd1,
        KIND_STATIC_BLOCK   = 3'd2,
        KIND_STATIC_UNBLOCK = 3'd3,
        KIND_QUERY          = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_OUTSIDE   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_CLR_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [MAP_W-1:0] map_width;
        logic [MAP_W-1:0] map_height;
        logic [CLR_W-1:0] clearance_limit;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
    } t_item;

    typedef struct packed {
        logic             is_blocked;
        logic             became_blocked;
        logic             became_free;
        logic             static_edge;
        logic [CLR_W-1:0] clearance;
        t_status          status;
    } t_result;

endpackage

>>> design/grid_block_count_and_clearance.sv
// ----------------------------------------------------------------------------
// grid_block_count_and_clearance
// Per-cell dynamic and static block counts with clearance queries.
// ----------------------------------------------------------------------------
// After reset the block clears its count store, one cell a cycle, through
// all GRID_SIDE*GRID_SIDE cells (4096 by default) and takes no item meanwhile;
// configuration writes are taken at any time. Block and unblock items, items
// outside the map, unused kinds, queries on a blocked cell and queries with an
// effective limit L of 1 are handled by a read of the count store, then a
// modify and write back. Any other query walks the L-shaped borders one cell
// per cycle through the store's single read port, visiting at most
// (L-1)*(L+2) border cells (238 for a limit of 15). One item is worked on at
// a time; the result register lets the next item in while a result waits on
// the output.
// ----------------------------------------------------------------------------
module grid_block_count_and_clearance #(
    parameter int GRID_SIDE           = gbc_pkg::DEF_GRID_SIDE,
    parameter int COUNT_BITS          = gbc_pkg::DEF_COUNT_BITS,
    parameter int MAX_CLEARANCE_BOUND = gbc_pkg::DEF_MAX_CLEARANCE_BOUND
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // kind[2:0], cell_x[8:3], cell_y[14:9], zero[15]
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [gbc_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // is_blocked[0], became_blocked[1], became_free[2], static_edge[3],
    // clearance[7:4], status[9:8], zero[15:10]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [gbc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import gbc_pkg::*;

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int MEM_W  = 2 * COUNT_BITS;

    t_cfg                    r_cfg;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    t_item                   w_item;
    t_result                 w_res;
    logic                    w_res_valid;
    logic                    w_out_free;
    logic                    w_mem_we;
    logic [ADDR_W-1:0]       w_mem_waddr;
    logic [MEM_W-1:0]        w_mem_wdata;
    logic [ADDR_W-1:0]       w_mem_raddr;
    logic [MEM_W-1:0]        w_mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width       <= RST_MAP_WIDTH;
            r_cfg.map_height      <= RST_MAP_HEIGHT;
            r_cfg.clearance_limit <= RST_CLR_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH:  r_cfg.map_width       <= i_cfg_data;
                CFG_MAP_HEIGHT: r_cfg.map_height      <= i_cfg_data;
                CFG_CLR_LIMIT:  r_cfg.clearance_limit <= i_cfg_data[CLR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_item.kind   = i_s_tdata[2:0];
    assign w_item.cell_x = i_s_tdata[8:3];
    assign w_item.cell_y = i_s_tdata[14:9];

    assign w_out_free = !r_out_valid || i_m_tready;

    gbc_seq #(
        .GRID_SIDE           (GRID_SIDE),
        .COUNT_BITS          (COUNT_BITS),
        .MAX_CLEARANCE_BOUND (MAX_CLEARANCE_BOUND),
        .ADDR_W              (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (i_s_tvalid),
        .o_item_ready (o_s_tready),
        .i_item       (w_item),
        .i_out_free   (w_out_free),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    gbc_count_ram #(
        .DEPTH  (CELLS),
        .DATA_W (MEM_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_data <= {6'b0, w_res.status, w_res.clearance, w_res.static_edge,
                           w_res.became_free, w_res.became_blocked, w_res.is_blocked};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> design/gbc_count_ram.sv
// ----------------------------------------------------------------------------
// gbc_count_ram
// Count store: one synchronous memory holding the static and dynamic counts
// of every cell, one write and one read port, read data registered.
// ----------------------------------------------------------------------------
module gbc_count_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/gbc_seq.sv
// ----------------------------------------------------------------------------
// gbc_seq
// Sequencer: clears the count store after reset, runs the read, modify and
// write of block and unblock items, and walks the L-shaped borders of a
// clearance query one cell per cycle through the store's read port.
// ----------------------------------------------------------------------------
module gbc_seq #(
    parameter int GRID_SIDE           = gbc_pkg::DEF_GRID_SIDE,
    parameter int COUNT_BITS          = gbc_pkg::DEF_COUNT_BITS,
    parameter int MAX_CLEARANCE_BOUND = gbc_pkg::DEF_MAX_CLEARANCE_BOUND,
    parameter int ADDR_W              = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gbc_pkg::t_cfg           i_cfg,
    input  logic                    i_item_valid,
    output logic                    o_item_ready,
    input  gbc_pkg::t_item          i_item,
    input  logic                    i_out_free,
    output logic                    o_res_valid,
    output gbc_pkg::t_result        o_res,
    output logic                    o_mem_we,
    output logic [ADDR_W-1:0]       o_mem_waddr,
    output logic [2*COUNT_BITS-1:0] o_mem_wdata,
    output logic [ADDR_W-1:0]       o_mem_raddr,
    input  logic [2*COUNT_BITS-1:0] i_mem_rdata
);

    import gbc_pkg::*;

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CALC_W = ADDR_W + SUM_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_PUSH
    } t_state;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SUM_W-1:0] x,
                                                    input logic [SUM_W-1:0] y);
        logic [CALC_W-1:0] p;
        p = CALC_W'(y) * CALC_W'(GRID_SIDE) + CALC_W'(x);
        return p[ADDR_W-1:0];
    endfunction

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [KIND_W-1:0]       r_kind;
    logic [COORD_W-1:0]      r_x;
    logic [COORD_W-1:0]      r_y;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_inside;
    t_result                 r_res;
    logic [CLR_W-1:0]        r_c;
    logic [CLR_W-1:0]        r_i;
    logic                    r_side;
    logic                    r_gen_on;
    logic                    r_tag_valid;
    logic [CLR_W-1:0]        r_tag_c;
    logic                    r_tag_out;
    logic                    r_tag_last;

    logic [MAP_W-1:0]        w_cols;
    logic [MAP_W-1:0]        w_rows;
    logic [CLR_W-1:0]        w_lim_cap;
    logic [CLR_W-1:0]        w_lim;
    logic                    w_in_inside;
    logic [COUNT_BITS-1:0]   w_dyn;
    logic [COUNT_BITS-1:0]   w_stat;
    logic                    w_was;
    logic [COUNT_BITS-1:0]   n_dyn;
    logic [COUNT_BITS-1:0]   n_stat;
    logic                    w_upd;
    logic                    w_start_scan;
    t_result                 w_mod_res;
    t_result                 w_scan_res;
    logic                    w_scan_done;
    logic [SUM_W-1:0]        w_gx;
    logic [SUM_W-1:0]        w_gy;
    logic                    w_g_out;
    logic                    w_g_last;

    always_comb begin
        w_cols = i_cfg.map_width;
        w_rows = i_cfg.map_height;
        if (GRID_SIDE < 2 ** MAP_W) begin
            if (MAP_W'(GRID_SIDE) < i_cfg.map_width) begin
                w_cols = MAP_W'(GRID_SIDE);
            end
            if (MAP_W'(GRID_SIDE) < i_cfg.map_height) begin
                w_rows = MAP_W'(GRID_SIDE);
            end
        end
        w_lim_cap = i_cfg.clearance_limit;
        if (MAX_CLEARANCE_BOUND < 2 ** CLR_W) begin
            if (i_cfg.clearance_limit > CLR_W'(MAX_CLEARANCE_BOUND)) begin
                w_lim_cap = CLR_W'(MAX_CLEARANCE_BOUND);
            end
        end
        w_lim = (w_lim_cap == '0) ? CLR_W'(1) : w_lim_cap;
    end

    assign w_in_inside = (SUM_W'(i_item.cell_x) < w_cols) && (SUM_W'(i_item.cell_y) < w_rows);

    assign w_dyn  = i_mem_rdata[COUNT_BITS-1:0];
    assign w_stat = i_mem_rdata[2*COUNT_BITS-1:COUNT_BITS];
    assign w_was  = (|w_dyn) || (|w_stat);

    always_comb begin
        n_dyn        = w_dyn;
        n_stat       = w_stat;
        w_upd        = 1'b0;
        w_start_scan = 1'b0;
        w_mod_res    = '0;
        w_mod_res.status = STATUS_OK;
        unique case (r_kind)
            KIND_BLOCK: begin
                if (&w_dyn) begin
                    w_mod_res.status = STATUS_OVERFLOW;
                end else begin
                    n_dyn = w_dyn + COUNT_BITS'(1);
                    w_upd = 1'b1;
                end
            end
            KIND_UNBLOCK: begin
                if (w_dyn == '0) begin
                    w_mod_res.status = STATUS_UNDERFLOW;
                end else begin
                    n_dyn = w_dyn - COUNT_BITS'(1);
                    w_upd = 1'b1;
                end
            end
            KIND_STATIC_BLOCK: begin
                if (&w_stat) begin
                    w_mod_res.status = STATUS_OVERFLOW;
                end else begin
                    n_stat = w_stat + COUNT_BITS'(1);
                    w_upd  = 1'b1;
                    w_mod_res.static_edge = (w_stat == '0);
                end
            end
            KIND_STATIC_UNBLOCK: begin
                if (w_stat == '0) begin
                    w_mod_res.status = STATUS_UNDERFLOW;
                end else begin
                    n_stat = w_stat - COUNT_BITS'(1);
                    w_upd  = 1'b1;
                    w_mod_res.static_edge = (w_stat == COUNT_BITS'(1));
                end
            end
            KIND_QUERY: begin
                if (!w_was) begin
                    if (w_lim == CLR_W'(1)) begin
                        w_mod_res.clearance = CLR_W'(1);
                    end else begin
                        w_start_scan = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        w_mod_res.is_blocked     = (|n_dyn) || (|n_stat);
        w_mod_res.became_blocked = !w_was && w_mod_res.is_blocked;
        w_mod_res.became_free    = w_was && !w_mod_res.is_blocked;
        if (!r_inside) begin
            w_mod_res        = '0;
            w_mod_res.status = STATUS_OUTSIDE;
            w_upd            = 1'b0;
            w_start_scan     = 1'b0;
        end
    end

    assign w_gx     = SUM_W'(r_x) + SUM_W'(r_side ? r_c : r_i);
    assign w_gy     = SUM_W'(r_y) + SUM_W'(r_side ? r_i : r_c);
    assign w_g_out  = !((w_gx < w_cols) && (w_gy < w_rows));
    assign w_g_last = r_side && (r_i == r_c) && (r_c == w_lim - CLR_W'(1));

    always_comb begin
        w_scan_res        = '0;
        w_scan_res.status = STATUS_OK;
        w_scan_res.clearance = (r_tag_out || w_was) ? r_tag_c : w_lim;
    end

    assign w_scan_done = r_tag_valid && (r_tag_out || w_was || r_tag_last);

    always_comb begin
        unique case (r_state)
            ST_MOD:  o_res = w_mod_res;
            ST_SCAN: o_res = w_scan_res;
            default: o_res = r_res;
        endcase
    end

    assign o_res_valid = i_out_free && (((r_state == ST_MOD) && !w_start_scan) ||
                                        ((r_state == ST_SCAN) && w_scan_done) ||
                                        (r_state == ST_PUSH));
    assign o_item_ready = (r_state == ST_IDLE);

    assign o_mem_raddr = (r_state == ST_IDLE) ?
                         cell_addr(SUM_W'(i_item.cell_x), SUM_W'(i_item.cell_y)) :
                         cell_addr(w_gx, w_gy);
    assign o_mem_we    = (r_state == ST_CLEAR) || ((r_state == ST_MOD) && w_upd);
    assign o_mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_addr;
    assign o_mem_wdata = (r_state == ST_CLEAR) ? '0 : {n_stat, n_dyn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_gen_on    <= 1'b0;
            r_tag_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_kind   <= i_item.kind;
                        r_x      <= i_item.cell_x;
                        r_y      <= i_item.cell_y;
                        r_addr   <= cell_addr(SUM_W'(i_item.cell_x), SUM_W'(i_item.cell_y));
                        r_inside <= w_in_inside;
                        r_state  <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (w_start_scan) begin
                        r_c         <= CLR_W'(1);
                        r_i         <= '0;
                        r_side      <= 1'b0;
                        r_gen_on    <= 1'b1;
                        r_tag_valid <= 1'b0;
                        r_state     <= ST_SCAN;
                    end else if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_res   <= w_mod_res;
                        r_state <= ST_PUSH;
                    end
                end
                ST_SCAN: begin
                    r_tag_valid <= r_gen_on && !w_scan_done;
                    r_tag_c     <= r_c;
                    r_tag_out   <= w_g_out;
                    r_tag_last  <= w_g_last;
                    if (r_gen_on) begin
                        if (!r_side) begin
                            r_side <= 1'b1;
                        end else begin
                            r_side <= 1'b0;
                            if (r_i == r_c) begin
                                r_i <= '0;
                                r_c <= r_c + CLR_W'(1);
                            end else begin
                                r_i <= r_i + CLR_W'(1);
                            end
                        end
                    end
                    if (w_scan_done || (r_gen_on && w_g_last)) begin
                        r_gen_on <= 1'b0;
                    end
                    if (w_scan_done) begin
                        if (i_out_free) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_res   <= w_scan_res;
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_PUSH: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
